// ===== sv/dhi_pkg.sv =====
package dhi_pkg;

	// default sizes
	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int NUM_VARIABLES_DEF = 8;
	localparam int SAMPLE_WIDTH_DEF  = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALFSTEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd4;

	// item kinds
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_ADVANCE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// interpolation modes
	localparam logic [1:0] MODE_NEAREST = 2'd0;
	localparam logic [1:0] MODE_LINEAR  = 2'd1;
	localparam logic [1:0] MODE_CUBIC   = 2'd2;

	// reset values of the registers
	localparam logic [1:0]  MODE_RST      = MODE_LINEAR;
	localparam logic [25:0] MAX_DELAY_RST = 26'd66977792;
	localparam logic [10:0] LENGTH_RST    = 11'd1024;

	// half-step window on the offset, Q1.16
	localparam logic [16:0] HALF_LO  = 17'd19661;
	localparam logic [16:0] HALF_HI  = 17'd45875;
	localparam logic [16:0] OFF_MAX  = 17'd65536;

	// reciprocal of three for values below 2^32
	localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         var_index;
		logic signed [31:0] sample_value;
		logic [25:0]        delay;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               status;
	} out_item_t;

endpackage

// ===== sv/dhi_if.sv =====
interface dhi_in_if import dhi_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface dhi_out_if import dhi_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== sv/delay_history_interpolator.sv =====
// Delay history interpolator.
// in_ch (sink) takes items: kind 0 writes one variable of the slot after the
// current-time pointer, kind 1 moves the pointer on, kind 2 reads one variable
// at a fractional delay; kind 3 is dropped. out_ch (source) gives one item
// (value, status) for every read. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce it. One item at a time. Every
// write, advance or read first reduces the pointer position modulo the ring
// length in a bit-serial remainder unit, one bit a cycle over VW bits (14 at
// the default depth). Writes and advances then finish in a fix step. Reads
// fetch four samples from the single history port, then take a select step;
// nearest and half-step results are ready after that, linear adds a sum
// step, full cubic adds coefficient products, divide by three, four tap
// products and a sum. Reads with a delay above the maximum return at once
// with status 1. Reset clears the pointer and sets the registers to their
// reset values; the history is undefined until written and needs no
// clearing. When the receiver stalls, the result waits in the output
// register and the next item is still taken and worked on; it waits for the
// register only at its own last step.
module delay_history_interpolator import dhi_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int NUM_VARIABLES = NUM_VARIABLES_DEF,
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dhi_in_if.sink                in_ch,
	dhi_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int EW = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int LW = $clog2(HISTORY_DEPTH + 1);
	localparam int VW = ((PW > 12) ? PW : 12) + 2;
	localparam int CW = $clog2(VW + 1);
	localparam int MD = HISTORY_DEPTH * NUM_VARIABLES;
	localparam int AW = $clog2(MD);

	typedef enum logic [3:0] {
		ST_IDLE, ST_REM, ST_FIX, ST_RD, ST_SEL, ST_LSUM,
		ST_CO1, ST_CO2, ST_CO3, ST_CO4, ST_MUL, ST_SUM, ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0]  mode_q;
	logic        hs_q;
	logic [16:0] off_q;
	logic [25:0] max_q;
	logic [10:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			hs_q   <= 1'b0;
			off_q  <= '0;
			max_q  <= MAX_DELAY_RST;
			len_q  <= LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q <= cfg_data[1:0];
				REG_HALFSTEP:  hs_q   <= cfg_data[0];
				REG_OFFSET:    off_q  <= cfg_data[16:0];
				REG_MAX_DELAY: max_q  <= cfg_data;
				REG_LENGTH:    len_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// ring length in use, clamped
	logic [LW-1:0] ring_len;
	always_comb begin
		if (len_q < 11'd4)
			ring_len = LW'(4);
		else if (32'(len_q) > 32'(HISTORY_DEPTH))
			ring_len = LW'(HISTORY_DEPTH);
		else
			ring_len = LW'(len_q);
	end

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] x, input logic [LW-1:0] l);
		logic [LW:0] s;
		s = (LW+1)'(x) + 1'b1;
		return (s == (LW+1)'(l)) ? '0 : PW'(s);
	endfunction

	function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] x, input logic [LW-1:0] l);
		return (x == '0) ? PW'(l - 1'b1) : PW'(x - 1'b1);
	endfunction

	// saturate to the sample width, sign-extended to 32 bits
	function automatic logic signed [31:0] sat_w(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (EW - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi)
			return 32'(hi);
		else if (x < lo)
			return 32'(lo);
		else
			return 32'(x);
	endfunction

	// offset, effective delay and its split
	logic [16:0]        off_c;
	logic signed [27:0] d_eff;
	assign off_c = (off_q > OFF_MAX) ? OFF_MAX : off_q;
	assign d_eff = signed'({2'b00, in_ch.item.delay}) - signed'({11'd0, off_c});

	// item registers
	in_item_t            item_q;
	logic [15:0]         f_q;
	logic                nrup_q;
	logic [PW-1:0]       ptr_q;

	// remainder unit
	logic [VW-1:0]  mag_q;
	logic           neg_q;
	logic [LW-1:0]  rem_q;
	logic [CW-1:0]  cnt_q;
	logic [LW:0]    rem_try;
	logic [PW-1:0]  pm;
	logic signed [VW-1:0] v_pos;

	assign v_pos   = signed'(VW'(ptr_q)) - VW'(signed'(d_eff[27:16]));
	assign rem_try = {rem_q, mag_q[VW-1]};
	assign pm      = (neg_q && rem_q != '0) ? PW'(ring_len - rem_q) : PW'(rem_q);

	// history memory
	logic [EW-1:0]   mem [MD];
	logic [EW-1:0]   rdata_q;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	logic            we;
	logic [PW-1:0]   slot_q [4];
	logic [PW-1:0]   wslot;

	assign wslot = ring_inc(pm, ring_len);
	assign waddr = AW'(wslot) * AW'(NUM_VARIABLES) + AW'(item_q.var_index);
	assign raddr = AW'(slot_q[cnt_q[1:0]]) * AW'(NUM_VARIABLES) + AW'(item_q.var_index);
	assign we    = (state_q == ST_FIX) && (item_q.kind == KIND_WRITE);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= item_q.sample_value[EW-1:0];
		rdata_q <= mem[raddr];
	end

	// samples p[n+2], p[n+1], p[n], p[n-1]
	logic signed [31:0] p_q [4];

	// arithmetic registers
	logic [17:0]         ca, cb, cc, ce;
	logic [35:0]         ab_q, ae_q, eb_q;
	logic [53:0]         abc_q, aec_q, ebc_q, abe_q;
	logic [31:0]         t0_q, t3_q, q1_q, q2_q, q0_q, q3_q;
	logic signed [63:0]  pr_q [4];
	logic signed [63:0]  x_lin, x_cub;
	logic signed [39:0]  x_half;
	logic signed [31:0]  y_q;
	logic                st_q;
	logic [63:0]         m0, m3;

	assign ca = {2'b00, f_q};
	assign cb = 18'd65536 - ca;
	assign cc = 18'd65536 + ca;
	assign ce = 18'd131072 - ca;
	assign m0 = t0_q * RECIP3;
	assign m3 = t3_q * RECIP3;

	assign x_lin  = pr_q[0] + pr_q[1] + 64'sd32768;
	assign x_cub  = pr_q[1] + pr_q[2] - pr_q[0] - pr_q[3] + 64'sd8388608;
	assign x_half = 40'sd9 * (40'(p_q[1]) + 40'(p_q[2])) - 40'(p_q[0]) - 40'(p_q[3])
		+ 40'sd8;

	logic half_win;
	assign half_win = (off_c >= HALF_LO) && (off_c <= HALF_HI);

	// handshakes
	logic      ov_q;
	out_item_t oitem_q;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.item  = oitem_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			// a result taken frees the register unless a new one is loaded
			if (ov_q && out_ch.ready && state_q != ST_DONE)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						item_q <= in_ch.item;
						f_q    <= d_eff[15:0];
						nrup_q <= (d_eff[15:0] > 16'd32768) ||
							(d_eff[15:0] == 16'd32768 && !d_eff[27]);
						rem_q  <= '0;
						cnt_q  <= '0;
						if (in_ch.item.kind == KIND_READ) begin
							mag_q <= v_pos[VW-1] ? VW'(-v_pos) : VW'(v_pos);
							neg_q <= v_pos[VW-1];
						end else begin
							mag_q <= VW'(ptr_q);
							neg_q <= 1'b0;
						end
						case (in_ch.item.kind)
							KIND_WRITE:
								if (32'(in_ch.item.var_index) < NUM_VARIABLES)
									state_q <= ST_REM;
							KIND_ADVANCE:
								state_q <= ST_REM;
							KIND_READ: begin
								y_q  <= '0;
								st_q <= in_ch.item.delay > max_q;
								if (in_ch.item.delay > max_q ||
									32'(in_ch.item.var_index) >= NUM_VARIABLES ||
									mode_q > MODE_CUBIC)
									state_q <= ST_DONE;
								else
									state_q <= ST_REM;
							end
							default: ;
						endcase
					end
				end
				// one remainder bit a cycle
				ST_REM: begin
					mag_q <= mag_q << 1;
					rem_q <= (rem_try >= (LW+1)'(ring_len)) ?
						LW'(rem_try - (LW+1)'(ring_len)) : LW'(rem_try);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(VW - 1))
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					cnt_q <= '0;
					if (item_q.kind == KIND_ADVANCE)
						ptr_q <= wslot;
					if (item_q.kind == KIND_READ) begin
						slot_q[0] <= ring_dec(ring_dec(pm, ring_len), ring_len);
						slot_q[1] <= ring_dec(pm, ring_len);
						slot_q[2] <= pm;
						slot_q[3] <= ring_inc(pm, ring_len);
						state_q   <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				// fetch four samples, data in the cycle after its address
				ST_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0)
						p_q[cnt_q[1:0] - 2'd1] <= 32'(signed'(rdata_q));
					if (cnt_q == CW'(4))
						state_q <= ST_SEL;
				end
				ST_SEL: begin
					case (mode_q)
						MODE_NEAREST: begin
							y_q     <= nrup_q ? p_q[1] : p_q[2];
							state_q <= ST_DONE;
						end
						MODE_LINEAR: begin
							pr_q[0] <= 64'(p_q[2] * signed'({1'b0, cb}));
							pr_q[1] <= 64'(p_q[1] * signed'({1'b0, ca}));
							state_q <= ST_LSUM;
						end
						default: begin
							if (hs_q) begin
								if (half_win)
									y_q <= sat_w(64'(x_half >>> 4));
								else
									y_q <= nrup_q ? p_q[1] : p_q[2];
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_CO1;
							end
						end
					endcase
				end
				ST_LSUM: begin
					y_q     <= sat_w(x_lin >>> 16);
					state_q <= ST_DONE;
				end
				// Lagrange weights
				ST_CO1: begin
					ab_q    <= 36'(ca * cb);
					ae_q    <= 36'(ca * ce);
					eb_q    <= 36'(ce * cb);
					state_q <= ST_CO2;
				end
				ST_CO2: begin
					abc_q   <= 54'(ab_q * cc);
					aec_q   <= 54'(ae_q * cc);
					ebc_q   <= 54'(eb_q * cc);
					abe_q   <= 54'(ab_q * ce);
					state_q <= ST_CO3;
				end
				ST_CO3: begin
					t0_q    <= 32'((abc_q + 54'd50331648) >> 25);
					q1_q    <= 32'((aec_q + 54'd16777216) >> 25);
					q2_q    <= 32'((ebc_q + 54'd16777216) >> 25);
					t3_q    <= 32'((abe_q + 54'd50331648) >> 25);
					state_q <= ST_CO4;
				end
				ST_CO4: begin
					q0_q    <= 32'(m0 >> 33);
					q3_q    <= 32'(m3 >> 33);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					pr_q[0] <= 64'(p_q[0] * signed'({1'b0, q0_q[25:0]}));
					pr_q[1] <= 64'(p_q[1] * signed'({1'b0, q1_q[25:0]}));
					pr_q[2] <= 64'(p_q[2] * signed'({1'b0, q2_q[25:0]}));
					pr_q[3] <= 64'(p_q[3] * signed'({1'b0, q3_q[25:0]}));
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					y_q     <= sat_w(x_cub >>> 24);
					state_q <= ST_DONE;
				end
				// hand the result to the output register
				ST_DONE: begin
					if (!ov_q || out_ch.ready) begin
						ov_q          <= 1'b1;
						oitem_q.value  <= y_q;
						oitem_q.status <= st_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/dhi_result_checker.sv =====
module dhi_result_checker import dhi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dhi_in_if                     in_ch,
	dhi_out_if                    out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// own copy of the ring, pointer and registers
	logic signed [31:0] hist [0:1023][0:7];
	int unsigned        wr_ptr;
	logic [1:0]         mode;
	logic               half;
	logic [16:0]        offset;
	logic [25:0]        max_dly;
	logic [10:0]        len_reg;
	int                 errs;
	out_item_t          due_results[$];

	function automatic longint ring_len();
		longint l;
		l = len_reg;
		if (l < 4) l = 4;
		if (l > 1024) l = 1024;
		return l;
	endfunction

	// sample of one variable, some steps before the pointer
	function automatic longint tap(longint back, int v);
		longint l, r;
		l = ring_len();
		r = (longint'(wr_ptr) % l - back) % l;
		if (r < 0) r += l;
		return longint'(hist[r][v]);
	endfunction

	// floor division by 2^s, rounded half up
	function automatic longint round_shr(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic out_item_t read_result(in_item_t it);
		longint off, d, n, nr, f, y, a, b, c, e, q0, q1, q2, q3, p0, p1, p2, p3;
		int v;
		out_item_t r;
		v = it.var_index;
		off = offset > OFF_MAX ? longint'(OFF_MAX) : longint'(offset);
		d = longint'(it.delay) - off;
		if (d >= 0) begin
			n = d / 65536;
			nr = (d + 32768) / 65536;
		end else begin
			n = -((-d + 65535) / 65536);
			nr = -((-d + 32768) / 65536);
		end
		f = d - n * 65536;
		y = 0;
		r.status = 1'b0;
		if (it.delay > max_dly) begin
			r.status = 1'b1;
		end else begin
			p0 = tap(n + 2, v);
			p1 = tap(n + 1, v);
			p2 = tap(n, v);
			p3 = tap(n - 1, v);
			case (mode)
				MODE_NEAREST: y = tap(nr, v);
				MODE_LINEAR: y = round_shr(p2 * (65536 - f) + p1 * f, 16);
				MODE_CUBIC: begin
					if (half) begin
						if (off >= HALF_LO && off <= HALF_HI)
							y = round_shr(-p0 + 9 * p1 + 9 * p2 - p3, 4);
						else
							y = tap(nr, v);
					end else begin
						a = f;
						b = 65536 - f;
						c = 65536 + f;
						e = 131072 - f;
						q0 = (a * b * c + (longint'(3) << 24)) / (longint'(6) << 24);
						q1 = (a * e * c + (longint'(1) << 24)) / (longint'(2) << 24);
						q2 = (e * b * c + (longint'(1) << 24)) / (longint'(2) << 24);
						q3 = (a * b * e + (longint'(3) << 24)) / (longint'(6) << 24);
						y = round_shr(-q0 * p0 + q1 * p1 + q2 * p2 - q3 * p3, 24);
					end
				end
				default: y = 0;
			endcase
			if (y > 64'sd2147483647) y = 64'sd2147483647;
			if (y < -64'sd2147483648) y = -64'sd2147483648;
		end
		r.value = y[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t got, w;
		longint l;
		if (!arst_n) begin
			wr_ptr = 0;
			mode = MODE_RST;
			half = 1'b0;
			offset = '0;
			max_dly = MAX_DELAY_RST;
			len_reg = LENGTH_RST;
			errs = 0;
			due_results.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode = cfg_data[1:0];
					REG_HALFSTEP: half = cfg_data[0];
					REG_OFFSET: offset = cfg_data[16:0];
					REG_MAX_DELAY: max_dly = cfg_data[25:0];
					REG_LENGTH: len_reg = cfg_data[10:0];
					default: ;
				endcase
			end
			// results against the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.item;
				if (due_results.size() == 0) begin
					$error("result item with nothing expected: value %0d status %0d",
						got.value, got.status);
					errs++;
				end else begin
					w = due_results.pop_front();
					if (got.value !== w.value) begin
						$error("value: expected %0d, got %0d", w.value, got.value);
						errs++;
					end
					if (got.status !== w.status) begin
						$error("status: expected %0d, got %0d", w.status, got.status);
						errs++;
					end
				end
			end
			// accepted input items
			if (in_ch.valid && in_ch.ready) begin
				l = ring_len();
				case (in_ch.item.kind)
					KIND_WRITE:
						hist[(longint'(wr_ptr) % l + 1) % l][in_ch.item.var_index] =
							in_ch.item.sample_value;
					KIND_ADVANCE: wr_ptr = (longint'(wr_ptr) % l + 1) % l;
					KIND_READ: due_results.push_back(read_result(in_ch.item));
					default: ;
				endcase
			end
			fails <= errs;
			pending <= due_results.size();
		end
	end

endmodule

// ===== bench/tb_delay_history_interpolator.sv =====
module tb_delay_history_interpolator;
	import dhi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [25:0] DLY_TOP = 26'h3FF_FFFF;
	localparam int LIMIT = 3_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int                    cycles;
	int                    stall_cnt;
	bit                    quiet;
	int                    cur_len;
	logic [25:0]           cur_max;
	int                    rd_vars;
	int                    fill_len [8];

	dhi_in_if  in_ch ();
	dhi_out_if out_ch ();

	delay_history_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dhi_result_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("delay_history_interpolator test failed");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (!quiet && stall_cnt == 0 && $urandom_range(7) == 0) begin
			stall_cnt <= $urandom_range(1, 5);
			out_ch.ready <= 1'b0;
		end else if (stall_cnt > 1) begin
			stall_cnt <= stall_cnt - 1;
		end else begin
			stall_cnt <= 0;
			out_ch.ready <= 1'b1;
		end
	end

	function automatic in_item_t mk(logic [1:0] k, int v, logic [31:0] s, logic [25:0] d);
		in_item_t it;
		it.kind = k;
		it.var_index = v[2:0];
		it.sample_value = s;
		it.delay = d;
		return it;
	endfunction

	// one item through the handshake, then perhaps a gap
	task automatic send(input in_item_t it);
		in_ch.item <= it;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (!quiet && $urandom_range(5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// hold off until every read has answered and the block has settled
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_regs(logic [1:0] m, logic h, logic [16:0] o, logic [25:0] md,
			logic [10:0] len);
		logic [CFG_DATA_W-1:0] vals [5];
		wait_idle();
		vals[REG_MODE] = CFG_DATA_W'(m);
		vals[REG_HALFSTEP] = CFG_DATA_W'(h);
		vals[REG_OFFSET] = CFG_DATA_W'(o);
		vals[REG_MAX_DELAY] = md;
		vals[REG_LENGTH] = CFG_DATA_W'(len);
		for (int i = REG_MODE; i <= REG_LENGTH; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_len = len < 4 ? 4 : (len > 1024 ? 1024 : len);
		cur_max = md;
	endtask

	// write every slot of the ring for the variables that will be read
	task automatic fill();
		bit need;
		need = 0;
		for (int v = 0; v < rd_vars; v++)
			if (fill_len[v] < cur_len) need = 1;
		if (need) begin
			for (int s = 0; s < cur_len; s++) begin
				for (int v = 0; v < rd_vars; v++)
					if (fill_len[v] < cur_len)
						send(mk(KIND_WRITE, v, $urandom, $urandom));
				send(mk(KIND_ADVANCE, $urandom_range(7), $urandom, $urandom));
			end
			for (int v = 0; v < rd_vars; v++)
				if (fill_len[v] < cur_len) fill_len[v] = cur_len;
		end
	endtask

	task automatic random_item();
		int r;
		int c;
		logic [25:0] dl;
		r = $urandom_range(99);
		c = $urandom_range(9);
		if (c == 0 || c == 9) dl = $urandom;
		else if (c == 7) dl = cur_max;
		else if (c == 8) dl = cur_max + 26'd1;
		else dl = $urandom_range(0, 8 << 16);
		if (r < 30)
			send(mk(KIND_WRITE, $urandom_range(7), $urandom, $urandom));
		else if (r < 50)
			send(mk(KIND_ADVANCE, $urandom_range(7), $urandom, $urandom));
		else if (r < 95)
			send(mk(KIND_READ, $urandom_range(rd_vars - 1), $urandom, dl));
		else
			send(mk(KIND_UNUSED, $urandom_range(7), $urandom, $urandom));
	endtask

	task automatic run_phase(logic [1:0] m, logic h, logic [16:0] o, logic [25:0] md,
			logic [10:0] len, int nv, int n, bit q);
		quiet = q;
		set_regs(m, h, o, md, len);
		rd_vars = nv;
		fill();
		repeat (n) random_item();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		out_ch.ready = 1'b0;
		cycles = 0;
		stall_cnt = 0;
		quiet = 1;
		rd_vars = 8;
		foreach (fill_len[i]) fill_len[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sample extremes on a four-slot ring, every mode
		set_regs(MODE_LINEAR, 1'b0, '0, DLY_TOP, 11'd4);
		fill();
		send(mk(KIND_WRITE, 0, 32'h7FFF_FFFF, '0));
		send(mk(KIND_WRITE, 1, 32'h8000_0000, '0));
		send(mk(KIND_ADVANCE, 0, '0, '0));
		send(mk(KIND_WRITE, 0, 32'h8000_0000, DLY_TOP));
		send(mk(KIND_WRITE, 1, 32'h7FFF_FFFF, DLY_TOP));
		send(mk(KIND_ADVANCE, 7, 32'hFFFF_FFFF, DLY_TOP));
		send(mk(KIND_UNUSED, 7, 32'hFFFF_FFFF, DLY_TOP));
		for (int i = 0; i < 4; i++) begin
			set_regs(i[1:0], 1'b0, '0, DLY_TOP, 11'd4);
			send(mk(KIND_READ, 0, '0, '0));
			send(mk(KIND_READ, 1, '0, 26'h1_8000));
			send(mk(KIND_READ, 0, '0, 26'h0_8000));
			send(mk(KIND_READ, 7, 32'hFFFF_FFFF, DLY_TOP));
		end
		// half-step window and a delay just over the maximum
		set_regs(MODE_CUBIC, 1'b1, 17'd32768, '0, 11'd4);
		send(mk(KIND_READ, 0, '0, '0));
		send(mk(KIND_READ, 1, '0, 26'd1));

		// random phases
		run_phase(MODE_NEAREST, 1'b0, '0, DLY_TOP, 11'd5, 8, 60, 0);
		run_phase(MODE_LINEAR, 1'b0, 17'd32768, DLY_TOP, 11'd16, 8, 60, 0);
		run_phase(MODE_CUBIC, 1'b0, '0, DLY_TOP, 11'd4, 8, 80, 0);
		run_phase(MODE_CUBIC, 1'b0, OFF_MAX, DLY_TOP, 11'd7, 8, 60, 0);
		run_phase(MODE_CUBIC, 1'b1, HALF_LO, DLY_TOP, 11'd11, 8, 60, 0);
		run_phase(MODE_CUBIC, 1'b1, HALF_HI, 26'd300000, 11'd11, 8, 50, 0);
		run_phase(MODE_CUBIC, 1'b1, HALF_LO - 17'd1, DLY_TOP, 11'd11, 8, 40, 0);
		run_phase(MODE_CUBIC, 1'b1, HALF_HI + 17'd1, DLY_TOP, 11'd9, 8, 40, 0);
		run_phase(MODE_CUBIC, 1'b0, 17'h1_FFFF, DLY_TOP, 11'd3, 8, 40, 0);
		run_phase(2'd3, 1'b0, '0, DLY_TOP, 11'd9, 8, 30, 0);
		run_phase(MODE_LINEAR, 1'b1, 17'd1, '0, 11'd40, 1, 40, 0);
		run_phase(MODE_CUBIC, 1'b0, 17'd12345, MAX_DELAY_RST, 11'd40, 1, 80, 0);
		run_phase(MODE_LINEAR, 1'b0, '0, MAX_DELAY_RST, 11'd24, 8, 100, 1);

		wait_idle();
		if (fails == 0 && pending == 0) begin
			$display("delay_history_interpolator test passed");
		end else begin
			$display("delay_history_interpolator test failed");
		end
		$finish;
	end

endmodule
